// ----- design/ttl_table_with_running_average_core_defines.svh -----
// assertion macros used by the ttl table core
// depends on nothing
`ifndef TTL_TABLE_WITH_RUNNING_AVERAGE_CORE_DEFINES_SVH
`define TTL_TABLE_WITH_RUNNING_AVERAGE_CORE_DEFINES_SVH
// implication checked at every edge out of reset
`define TTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define TTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/ttl_pkg.sv -----
// types and constants of the ttl table with running average
// depends on nothing
package ttl_pkg;
    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_GET  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DIV,
        S_OUT
    } state_t;
endpackage

// ----- design/ttl_ram.sv -----
// generic single-port-write ram with registered read
// depends on nothing
module ttl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/ttl_table_with_running_average_core.sv -----
// top level of the ttl table with running average
// depends on ttl_pkg, ttl_ram and the defines header
// Each beat is a put, get or tick. The block reads the entry memory one slot
// a cycle during the scan, then writes back for a put (a tick folds up to
// ENTRIES invalidations into the scan), then a restoring divider forms the
// average from a load step, one cycle per bit of the sum (37 bits at 16
// entries) and a step to fill the output register, and the result is held
// in an output register until m_tready. One item is in work at a time.
// Valid bits sit in flip-flops, so no clearing pass follows reset.
`include "ttl_table_with_running_average_core_defines.svh"
module ttl_table_with_running_average_core
    import ttl_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // cmd[1:0], key[33:2], value[65:34], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // status, found_value, live_sum, live_count, average
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SUM_W = (ENTRIES > 16) ? 33 + $clog2(ENTRIES) : 37;

    state_t state_reg, state_next;
    logic [15:0]       ttl_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]       now_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]     count_reg;
    logic [1:0]        cmd_reg;
    logic [31:0]       key_reg, value_reg;
    logic [AW:0]       idx_reg;
    logic              hit_reg, free_reg;
    logic [AW-1:0]     slot_reg, free_slot_reg;
    logic [31:0]       found_reg;
    logic [1:0]        status_reg;
    logic [SUM_W-1:0]  quo_reg, rem_reg, dvd_reg;
    logic [5:0]        dcnt_reg;
    logic              neg_reg;
    logic [111:0]      out_reg;

    // memory reads for idx_reg-1 come back while idx_reg is current
    logic [AW-1:0]  raddr, waddr;
    logic           we;
    logic [31:0]    rkey, rval, rexp, wval, wexp;
    logic [AW-1:0]  pidx;
    logic           pvalid;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, ttl_reg} : 32'd0;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = out_reg;

    assign raddr  = idx_reg[AW-1:0];
    assign pidx   = AW'(idx_reg - 1'b1);
    assign pvalid = (idx_reg != '0) && valid_reg[pidx];
    assign we     = (state_reg == S_WRITE) && (cmd_reg == CMD_PUT) && (hit_reg || free_reg);
    assign waddr  = hit_reg ? slot_reg : free_slot_reg;
    assign wval   = value_reg;
    assign wexp   = now_reg + {16'd0, ttl_reg};

    ttl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (.clk(clk), .we(we && !hit_reg),
        .waddr(waddr), .wdata(key_reg), .raddr(raddr), .rdata(rkey));
    ttl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val (.clk(clk), .we(we),
        .waddr(waddr), .wdata(wval), .raddr(raddr), .rdata(rval));
    ttl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_exp (.clk(clk), .we(we),
        .waddr(waddr), .wdata(wexp), .raddr(raddr), .rdata(rexp));

    logic [31:0] dlt;
    logic        expired;
    assign dlt     = now_reg - rexp;
    assign expired = (dlt != 32'd0) && !dlt[31];

    logic [SUM_W:0] trial;
    assign trial = {rem_reg, dvd_reg[SUM_W-1]} - {{(SUM_W+1-CW){1'b0}}, count_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_SCAN;
            S_SCAN:  if (idx_reg == (AW+1)'(ENTRIES)) state_next = S_WRITE;
            S_WRITE: state_next = S_DIV;
            S_DIV:   if (dcnt_reg == 6'd0) state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ttl_reg   <= '0;
            valid_reg <= '0;
            now_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == 3'd0)
            begin
                ttl_reg <= pwdata[15:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (s_tvalid && s_tdata[1:0] == CMD_TICK)
                    begin
                        now_reg <= now_reg + 32'd1;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (pvalid && cmd_reg == CMD_TICK && expired)
                    begin
                        valid_reg[pidx] <= 1'b0;
                        sum_reg   <= sum_reg - {{(SUM_W-32){rval[31]}}, rval};
                        count_reg <= count_reg - 1'b1;
                    end
                end
                S_WRITE:
                begin
                    if (cmd_reg == CMD_PUT && hit_reg)
                    begin
                        sum_reg <= sum_reg - {{(SUM_W-32){found_reg[31]}}, found_reg}
                            + {{(SUM_W-32){value_reg[31]}}, value_reg};
                    end
                    else if (cmd_reg == CMD_PUT && free_reg)
                    begin
                        valid_reg[free_slot_reg] <= 1'b1;
                        sum_reg   <= sum_reg + {{(SUM_W-32){value_reg[31]}}, value_reg};
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg   <= s_tdata[1:0];
                key_reg   <= s_tdata[33:2];
                value_reg <= s_tdata[65:34];
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                found_reg <= '0;
            end
            S_SCAN:
            begin
                if (idx_reg != '0)
                begin
                    if (pvalid && rkey == key_reg && !hit_reg)
                    begin
                        hit_reg   <= 1'b1;
                        slot_reg  <= pidx;
                        found_reg <= rval;
                    end
                    if (!valid_reg[pidx] && !free_reg)
                    begin
                        free_reg      <= 1'b1;
                        free_slot_reg <= pidx;
                    end
                end
            end
            S_WRITE:
            begin
                if (cmd_reg == CMD_PUT && !hit_reg && !free_reg)
                    status_reg <= ST_FULL;
                else if (cmd_reg == CMD_GET && !hit_reg)
                    status_reg <= ST_MISS;
                else
                    status_reg <= ST_OK;
                if (cmd_reg != CMD_GET)
                    found_reg <= '0;
                dcnt_reg <= 6'(SUM_W + 1);
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            S_DIV:
            begin
                if (dcnt_reg == 6'(SUM_W + 1))
                begin
                    neg_reg <= sum_reg[SUM_W-1];
                    dvd_reg <= sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
                else if (dcnt_reg != 6'd0)
                begin
                    if (!trial[SUM_W])
                    begin
                        rem_reg <= trial[SUM_W-1:0];
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[SUM_W-2:0], dvd_reg[SUM_W-1]};
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    dvd_reg  <= {dvd_reg[SUM_W-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
                else
                begin
                    out_reg <= {5'd0,
                        (count_reg == '0) ? 32'd0
                            : (neg_reg ? 32'(-quo_reg) : quo_reg[31:0]),
                        5'(count_reg), sum_reg[35:0], found_reg, status_reg};
                end
            end
            default: ;
        endcase
    end

    `TTL_ASSERT_IMP(a_out_idle, clk, rst_n, m_tvalid, !s_tready)
    `TTL_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, count_reg <= CW'(ENTRIES))
    `TTL_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

// ----- test/ttl_table_with_running_average_core_test.sv -----
// self-checking testbench for the ttl table with running average
// drives put/get/tick beats over the stream ports and the ttl register over apb
// depends on ttl_pkg and ttl_table_with_running_average_core
`timescale 1ns / 1ps
module ttl_table_with_running_average_core_test;
    import ttl_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [2:0] ADDR_TTL = 3'd0;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found;
        logic [35:0] sum;
        logic [4:0]  count;
        logic [31:0] avg;
    } result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] value;
        bit          fixed;
        result_t     res;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;     // cmd, key, value, zero pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;          // status, found_value, live_sum, live_count, average
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    ttl_table_with_running_average_core DUT (.*);

    always #1 clk = ~clk;

    // mirror of the table
    logic [15:0] cur_ttl;
    bit          slot_live [SLOTS];
    logic [31:0] slot_key [SLOTS];
    logic [31:0] slot_val [SLOTS];
    logic [31:0] slot_exp [SLOTS];
    logic [31:0] now_ticks;
    longint      live_total;
    int          live_entries;

    result_t     pending_results [$];
    int          failures = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          full_hits = 0;
    bit          rx_no_stall = 1'b0;

    function automatic result_t table_step(logic [1:0] cmd, logic [31:0] key,
                                           logic [31:0] value);
        result_t r;
        int slot;
        logic [31:0] d;
        r = '0;
        slot = -1;
        if (cmd == CMD_PUT || cmd == CMD_GET)
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && slot_live[i] && slot_key[i] == key)
                    slot = i;
        if (cmd == CMD_PUT) begin
            if (slot >= 0)
                live_total -= longint'($signed(slot_val[slot]));
            else begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !slot_live[i])
                        slot = i;
                if (slot >= 0) begin
                    slot_live[slot] = 1'b1;
                    slot_key[slot] = key;
                    live_entries++;
                end
            end
            if (slot >= 0) begin
                slot_val[slot] = value;
                slot_exp[slot] = now_ticks + 32'(cur_ttl);
                live_total += longint'($signed(value));
            end else begin
                r.status = ST_FULL;
                full_hits++;
            end
        end else if (cmd == CMD_GET) begin
            if (slot >= 0)
                r.found = slot_val[slot];
            else
                r.status = ST_MISS;
        end else if (cmd == CMD_TICK) begin
            now_ticks++;
            for (int i = 0; i < SLOTS; i++) begin
                d = now_ticks - slot_exp[i];
                if (slot_live[i] && d != 0 && !d[31]) begin
                    slot_live[i] = 1'b0;
                    live_total -= longint'($signed(slot_val[i]));
                    live_entries--;
                end
            end
        end
        r.sum = live_total[35:0];
        r.count = live_entries[4:0];
        r.avg = (live_entries != 0) ? 32'(live_total / longint'(live_entries)) : '0;
        return r;
    endfunction

    function automatic stim_row_t row(logic [1:0] cmd, logic [31:0] key,
                                      logic [31:0] value, bit fixed = 0,
                                      result_t res = '0);
        stim_row_t s;
        s.cmd = cmd;
        s.key = key;
        s.value = value;
        s.fixed = fixed;
        s.res = res;
        return s;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(logic [1:0] cmd, logic [31:0] key, logic [31:0] value,
                             bit fixed, result_t res, bit no_gap);
        result_t predicted;
        s_tvalid = 1'b1;
        s_tdata = {6'd0, value, key, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = table_step(cmd, key, value);
        pending_results.push_back(fixed ? res : predicted);
        beats_in++;
        @(negedge clk);
        if (!no_gap) begin
            int g;
            g = gap_len();
            if (g > 0) begin
                s_tvalid = 1'b0;
                repeat (g) @(negedge clk);
            end
        end
    endtask

    task automatic write_ttl(logic [15:0] val);
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (80) @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_TTL;
        pwdata = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cur_ttl = val;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.found = m_tdata[33:2];
            got.sum = m_tdata[69:34];
            got.count = m_tdata[74:70];
            got.avg = m_tdata[106:75];
            beats_out++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    failures++;
                end
                if (got.found !== want.found) begin
                    $error("found_value expected %h got %h", want.found, got.found);
                    failures++;
                end
                if (got.sum !== want.sum) begin
                    $error("live_sum expected %h got %h", want.sum, got.sum);
                    failures++;
                end
                if (got.count !== want.count) begin
                    $error("live_count expected %0d got %0d", want.count, got.count);
                    failures++;
                end
                if (got.avg !== want.avg) begin
                    $error("average expected %h got %h", want.avg, got.avg);
                    failures++;
                end
            end
        end
    end

    // receiver backpressure
    initial
    begin
        int g;
        forever begin
            @(negedge clk);
            m_tready = 1'b1;
            if (!rx_no_stall) begin
                repeat ($urandom_range(0, 4)) @(negedge clk);
                g = gap_len();
                if (g > 0) begin
                    m_tready = 1'b0;
                    repeat (g) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        stim_row_t dir [$];
        logic [15:0] ttl_plan [6];
        logic [1:0] c;
        logic [31:0] k;
        logic [31:0] v;
        int r;
        bit burst;

        cur_ttl = '0;
        now_ticks = '0;
        live_total = 0;
        live_entries = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_exp[i] = '0;
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ttl is zero after reset, so the first tick expires everything put before it
        dir.push_back(row(CMD_GET, 32'h0, 32'h0, 1, '{ST_MISS, 32'h0, 36'h0, 5'd0, 32'h0}));
        dir.push_back(row(CMD_TICK, 32'h0, 32'h0, 1, '{ST_OK, 32'h0, 36'h0, 5'd0, 32'h0}));
        dir.push_back(row(CMD_PUT, 32'hFFFFFFFF, 32'h7FFFFFFF, 1,
                          '{ST_OK, 32'h0, 36'h07FFFFFFF, 5'd1, 32'h7FFFFFFF}));
        dir.push_back(row(CMD_PUT, 32'h0, 32'h80000000));
        dir.push_back(row(CMD_GET, 32'hFFFFFFFF, 32'h0));
        dir.push_back(row(CMD_GET, 32'h0, 32'hFFFFFFFF));
        dir.push_back(row(CMD_PUT, 32'h0, 32'h00000001));
        dir.push_back(row(CMD_SPARE, 32'hAAAAAAAA, 32'h55555555));
        dir.push_back(row(CMD_GET, 32'h12345678, 32'h0));
        dir.push_back(row(CMD_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF));
        dir.push_back(row(CMD_GET, 32'h0, 32'h0));
        dir.push_back(row(CMD_PUT, 32'h5, 32'h00010000));
        dir.push_back(row(CMD_PUT, 32'h6, 32'hFFFF0000));
        dir.push_back(row(CMD_PUT, 32'h55555555, 32'h80000000));
        dir.push_back(row(CMD_PUT, 32'hAAAAAAAA, 32'h80000000));
        dir.push_back(row(CMD_PUT, 32'h5, 32'h80000000));
        dir.push_back(row(CMD_GET, 32'hAAAAAAAA, 32'h0));
        dir.push_back(row(CMD_TICK, 32'h0, 32'h0));
        dir.push_back(row(CMD_GET, 32'h55555555, 32'h0));
        foreach (dir[i])
            send_beat(dir[i].cmd, dir[i].key, dir[i].value, dir[i].fixed, dir[i].res, 0);

        // small lifetimes first, the longest last since it leaves the table full
        ttl_plan = '{16'd0, 16'd3, 16'd1, 16'd40, 16'($urandom_range(0, 20)), 16'hFFFF};
        foreach (ttl_plan[p]) begin
            write_ttl(ttl_plan[p]);
            rx_no_stall = (p == 2);
            for (int n = 0; n < 150; n++) begin
                r = $urandom_range(0, 99);
                c = (r < 45) ? CMD_PUT : (r < 75) ? CMD_GET : (r < 93) ? CMD_TICK :
                    (r < 96) ? CMD_SPARE : 2'($urandom);
                k = ($urandom_range(0, 99) < 85) ? 32'($urandom_range(0, 23)) : $urandom;
                r = $urandom_range(0, 9);
                v = (r == 0) ? 32'h7FFFFFFF : (r == 1) ? 32'h80000000 : $urandom;
                burst = (n % 50) < 12;
                send_beat(c, k, v, 0, '0, burst);
            end
        end
        s_tvalid = 1'b0;

        wait (pending_results.size() == 0);
        repeat (100) @(negedge clk);
        $display("%0d beats sent, %0d results checked, %0d rejected puts, six ttl settings",
                 beats_in, beats_out, full_hits);
        if (failures == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/ttl_pkg.sv
design/ttl_ram.sv
design/ttl_table_with_running_average_core.sv
test/ttl_table_with_running_average_core_test.sv
